[sv/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define MQE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mqe assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define MQE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqe assertion failed");

`endif

[sv/mqe_pkg.sv]
package mqe_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 76;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned SEG_NUM = 9;

  typedef enum logic [3:0] {
    SEG_FOLD,
    SEG_OPEN,
    SEG_WRAP_A,
    SEG_BAD_A,
    SEG_WRAP_M,
    SEG_MAIN,
    SEG_WRAP_B,
    SEG_BAD_B,
    SEG_CLOSE
  } seg_e;

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_QUESTION   = 8'h3F;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_DEL        = 8'h7F;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;

  typedef struct packed {
    logic [SEG_NUM-1:0] seg;
    logic               main_esc;
    logic [1:0]         main_last;
    logic [3:0][7:0]    octets;
  } job_t;

  // Characters of the line wrap; the fold and the opening are slices of it.
  function automatic logic [7:0] wrap_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = CH_QUESTION;
      4'd1:    c = CH_EQUAL;
      4'd2:    c = CH_NEWLINE;
      4'd3:    c = CH_TAB;
      4'd4:    c = CH_EQUAL;
      4'd5:    c = CH_QUESTION;
      4'd6:    c = 8'h75;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h66;
      4'd9:    c = 8'h2D;
      4'd10:   c = 8'h38;
      4'd11:   c = CH_QUESTION;
      4'd12:   c = 8'h71;
      4'd13:   c = CH_QUESTION;
      default: c = CH_QUESTION;
    endcase
    return c;
  endfunction

  // Escaped replacement character.
  function automatic logic [7:0] bad_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0, 4'd3, 4'd6: c = CH_EQUAL;
      4'd1:             c = 8'h45;
      4'd2, 4'd5:       c = 8'h46;
      4'd4, 4'd7:       c = 8'h42;
      4'd8:             c = 8'h44;
      default:          c = CH_EQUAL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

endpackage

[sv/mqe_front.sv]
module mqe_front import mqe_pkg::*; #(
  parameter int unsigned LineLimit = LINE_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam int unsigned RoomW = $clog2(LineLimit - 11);
  localparam int unsigned ColW  = (RoomW > 8) ? RoomW : 8;
  localparam logic [RoomW-1:0] RoomWrap  = RoomW'(LineLimit - 13);
  localparam logic [ColW-1:0]  FoldCol   = ColW'(LineLimit - 15);
  localparam logic [ColW-1:0]  FirstRoom = ColW'(LineLimit - 12);

  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadED = 8'hED;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF4 = 8'hF4;
  localparam logic [7:0] LeadC2 = 8'hC2;

  logic [7:0]       start_col_q;
  logic             word_open_q, word_open_d;
  logic [RoomW-1:0] room_q, room_d;
  logic             bad_run_q, bad_run_d;
  logic [1:0]       pcnt_q, pcnt_d;
  logic [2:0]       elen_q, elen_d;
  logic [7:0]       pend_q [3];
  logic             pend_we;
  logic [1:0]       pend_idx;
  logic             accept;
  job_t             job;

  function automatic logic [RoomW:0] make_room(input logic [RoomW-1:0] r,
                                               input logic [3:0] need);
    logic             w;
    logic [RoomW-1:0] base;
    w    = r < RoomW'(need);
    base = w ? RoomWrap : r;
    return {w, base - RoomW'(need)};
  endfunction

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  always_comb begin
    logic [7:0]       b;
    logic             fold;
    logic             held;
    logic             fits;
    logic             complete;
    logic             fresh;
    logic             bad_req;
    logic             is_esc;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic [2:0]       cnt3;
    logic [3:0]       need;
    logic [1:0]       pc_in;
    logic [RoomW:0]   mr;
    b           = data_byte_i;
    room_d      = room_q;
    bad_run_d   = bad_run_q;
    pcnt_d      = pcnt_q;
    elen_d      = elen_q;
    word_open_d = word_open_q;
    pend_we     = 1'b0;
    pend_idx    = 2'd0;
    job         = '0;
    fold        = 1'b0;
    complete    = 1'b0;
    bad_req     = 1'b0;
    need        = 4'd1;
    lo          = 8'h80;
    hi          = 8'hBF;
    mr          = '0;
    is_esc      = (b == CH_EQUAL) || (b == CH_QUESTION) || (b == CH_UNDERSCORE) ||
                  (b < CH_SPACE) || (b == CH_DEL);

    if (!word_open_q) begin
      fold               = ColW'(start_col_q) >= FoldCol;
      job.seg[SEG_FOLD]  = fold;
      job.seg[SEG_OPEN]  = 1'b1;
      room_d             = fold ? RoomWrap : RoomW'(FirstRoom - ColW'(start_col_q));
      bad_run_d          = 1'b0;
      pcnt_d             = 2'd0;
    end

    pc_in = pcnt_d;
    held  = pc_in != 2'd0;
    fresh = !held;
    cnt3  = {1'b0, pc_in} + 3'd1;

    if (pc_in == 2'd1) begin
      priority if (pend_q[0] == LeadE0) lo = 8'hA0;
      else if (pend_q[0] == LeadED) hi = 8'h9F;
      else if (pend_q[0] == LeadF0) lo = 8'h90;
      else if (pend_q[0] == LeadF4) hi = 8'h8F;
      else hi = 8'hBF;
    end
    fits = (b >= lo) && (b <= hi);

    if (held) begin
      if (fits) begin
        if (cnt3 >= elen_d) begin
          complete = 1'b1;
        end else begin
          pend_we  = 1'b1;
          pend_idx = pc_in;
          pcnt_d   = pc_in + 2'd1;
        end
      end else begin
        bad_req = 1'b1;
        fresh   = 1'b1;
        pcnt_d  = 2'd0;
      end
    end else if (b >= 8'h80 && !(b >= LeadC2 && b <= LeadF4)) begin
      bad_req = 1'b1;
    end

    if (bad_req) begin
      if (!bad_run_d) begin
        mr                  = make_room(room_d, 4'd9);
        job.seg[SEG_WRAP_A] = mr[RoomW];
        job.seg[SEG_BAD_A]  = 1'b1;
        room_d              = mr[RoomW-1:0];
      end
      bad_run_d = 1'b1;
    end

    for (int i = 0; i < 3; i++) begin
      job.octets[i] = (2'(i) == pc_in) ? b : pend_q[i];
    end
    job.octets[3] = b;

    if (complete) begin
      need          = {cnt3, 1'b0} + {1'b0, cnt3};
      job.main_esc  = 1'b1;
      job.main_last = pc_in;
      pcnt_d        = 2'd0;
    end else if (fresh) begin
      job.octets[0] = (b == CH_SPACE) ? CH_UNDERSCORE : b;
      if (is_esc) begin
        need         = 4'd3;
        job.main_esc = 1'b1;
      end
    end

    if (complete || (fresh && b < 8'h80)) begin
      mr                  = make_room(room_d, need);
      job.seg[SEG_WRAP_M] = mr[RoomW];
      job.seg[SEG_MAIN]   = 1'b1;
      room_d              = mr[RoomW-1:0];
      bad_run_d           = 1'b0;
    end else if (fresh && b >= LeadC2 && b <= LeadF4) begin
      pend_we  = 1'b1;
      pend_idx = 2'd0;
      pcnt_d   = 2'd1;
      elen_d   = (b < LeadE0) ? 3'd2 : ((b < LeadF0) ? 3'd3 : 3'd4);
    end

    if (end_of_text_i) begin
      if (pcnt_d != 2'd0 && !bad_run_d) begin
        mr                  = make_room(room_d, 4'd9);
        job.seg[SEG_WRAP_B] = mr[RoomW];
        job.seg[SEG_BAD_B]  = 1'b1;
        room_d              = mr[RoomW-1:0];
      end
      pcnt_d             = 2'd0;
      job.seg[SEG_CLOSE] = 1'b1;
      word_open_d        = 1'b0;
      bad_run_d          = 1'b0;
    end else begin
      word_open_d = 1'b1;
    end
  end

  assign push_o = accept && (job.seg != '0);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_col_q <= '0;
      word_open_q <= 1'b0;
      room_q      <= '0;
      bad_run_q   <= 1'b0;
      pcnt_q      <= '0;
      elen_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        start_col_q <= cfg_wdata_i;
      end
      if (accept) begin
        word_open_q <= word_open_d;
        room_q      <= room_d;
        bad_run_q   <= bad_run_d;
        pcnt_q      <= pcnt_d;
        elen_q      <= elen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pend_we) begin
      pend_q[pend_idx] <= data_byte_i;
    end
  end

endmodule

[sv/mqe_queue.sv]
module mqe_queue import mqe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/mqe_back.sv]
module mqe_back import mqe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       word_done_o
);

  job_t               job_q;
  logic [SEG_NUM-1:0] mask_q, mask_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [1:0]         oct_q, oct_d;
  logic               out_valid_q;
  logic [7:0]         out_char_q;
  logic               run_last_q;
  logic               word_done_q;

  seg_e               cur;
  logic               adv;
  logic               emit;
  logic               seg_end;
  logic               job_end;
  logic [7:0]         ch;
  logic [7:0]         octet;
  logic               done;
  logic [SEG_NUM-1:0] rest;

  always_comb begin
    cur = SEG_CLOSE;
    for (int i = SEG_NUM - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        cur = seg_e'(4'(i));
      end
    end
  end

  assign octet = job_q.octets[oct_q];

  always_comb begin
    ch      = CH_QUESTION;
    seg_end = 1'b0;
    done    = 1'b0;
    unique case (cur)
      SEG_FOLD: begin
        ch      = wrap_char(cnt_q + 4'd2);
        seg_end = cnt_q == 4'd1;
      end
      SEG_OPEN: begin
        ch      = wrap_char(cnt_q + 4'd4);
        seg_end = cnt_q == 4'd9;
      end
      SEG_WRAP_A, SEG_WRAP_M, SEG_WRAP_B: begin
        ch      = wrap_char(cnt_q);
        seg_end = cnt_q == 4'd13;
      end
      SEG_BAD_A, SEG_BAD_B: begin
        ch      = bad_char(cnt_q);
        seg_end = cnt_q == 4'd8;
      end
      SEG_MAIN: begin
        if (!job_q.main_esc) begin
          ch      = job_q.octets[0];
          seg_end = 1'b1;
        end else begin
          unique case (cnt_q)
            4'd0:    ch = CH_EQUAL;
            4'd1:    ch = hex_char(octet[7:4]);
            default: ch = hex_char(octet[3:0]);
          endcase
          seg_end = (cnt_q == 4'd2) && (oct_q == job_q.main_last);
        end
      end
      SEG_CLOSE: begin
        ch      = wrap_char(cnt_q);
        seg_end = cnt_q == 4'd1;
        done    = cnt_q == 4'd1;
      end
      default: begin
        ch      = CH_QUESTION;
        seg_end = 1'b1;
      end
    endcase
  end

  assign rest    = mask_q & ~(SEG_NUM'(1) << cur);
  assign adv     = !out_valid_q || !out_stall_i;
  assign emit    = adv && (mask_q != '0);
  assign job_end = seg_end && (rest == '0);
  assign pop_o   = job_valid_i && ((mask_q == '0) || (emit && job_end));

  always_comb begin
    mask_d = mask_q;
    cnt_d  = cnt_q;
    oct_d  = oct_q;
    if (emit) begin
      if (seg_end) begin
        mask_d = rest;
        cnt_d  = '0;
        oct_d  = '0;
      end else if (cur == SEG_MAIN && cnt_q == 4'd2) begin
        cnt_d = '0;
        oct_d = oct_q + 2'd1;
      end else begin
        cnt_d = cnt_q + 4'd1;
      end
    end
    if (pop_o) begin
      mask_d = job_i.seg;
      cnt_d  = '0;
      oct_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      cnt_q       <= '0;
      oct_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      cnt_q  <= cnt_d;
      oct_q  <= oct_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_char_q  <= ch;
      run_last_q  <= job_end;
      word_done_q <= done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;
  assign word_done_o = word_done_q;

endmodule

[sv/mime_q_header_encoder.sv]
// A taken byte that yields output becomes a job in the four-entry job queue, is loaded
// into the back end and is sent through a registered output stage. Throughput: one
// input byte per cycle while the queue has room; the output side sends one character
// per cycle while out_stall_i is low and holds each job until its characters are sent.
// Reset: rst_ni is asynchronous and active low; it empties the queue, closes any open
// word and sets the start column to zero.
module mime_q_header_encoder import mqe_pkg::*; #(
  parameter int unsigned LineLimit = LINE_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       word_done_o
);

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  logic head_valid;
  job_t head_job;

  mqe_front #(
    .LineLimit(LineLimit)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .end_of_text_i(end_of_text_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  mqe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_job)
  );

  mqe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(head_valid),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .run_last_o (run_last_o),
    .word_done_o(word_done_o)
  );

endmodule

[sv/mqe_checker.sv]
`include "assert_macros.svh"

module mqe_checker import mqe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [7:0] out_char_i,
  input logic       run_last_i,
  input logic       word_done_i
);

  logic       done_shown;
  logic       done_ok;
  logic       char_ok;
  logic       nl_taken;
  logic       tab_shown;
  logic       stalled;
  logic [9:0] payload;

  assign done_shown = out_valid_i && word_done_i;
  assign done_ok    = run_last_i && (out_char_i == CH_EQUAL);
  assign char_ok    = (out_char_i >= CH_SPACE && out_char_i <= CH_TILDE) ||
                      (out_char_i == CH_NEWLINE) || (out_char_i == CH_TAB);
  assign nl_taken   = out_valid_i && !out_stall_i && (out_char_i == CH_NEWLINE);
  assign tab_shown  = out_valid_i && (out_char_i == CH_TAB);
  assign stalled    = out_valid_i && out_stall_i;
  assign payload    = {out_char_i, run_last_i, word_done_i};

  `MQE_ASSERT(a_done_is_last_equal, clk_i, rst_ni, done_shown |-> done_ok)
  `MQE_ASSERT(a_char_printable, clk_i, rst_ni, out_valid_i |-> char_ok)
  `MQE_ASSERT_NEXT(a_newline_then_tab, clk_i, rst_ni, nl_taken, tab_shown)
  `MQE_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, stalled, out_valid_i && $stable(payload))

endmodule

bind mime_q_header_encoder mqe_checker u_mqe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_char_i (out_char_o),
  .run_last_i (run_last_o),
  .word_done_i(word_done_o)
);
